/* rtl/rhc_pkg.sv */
// rhc_pkg: shared types, constants and the falloff alpha table for the
// radial highlight compositor. No dependencies.
package rhc_pkg;

  localparam int ROOT_W       = 8;
  localparam int PIPE_STAGES  = 2 * ROOT_W;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] ALPHA_MAIN_CORE   = 8'd210;
  localparam logic [7:0] ALPHA_SECOND_CORE = 8'd180;
  localparam logic [7:0] ALPHA_SECOND_RING = 8'd120;
  localparam logic [7:0] ALPHA_MIN_APPLY   = 8'd5;
  localparam logic [7:0] ALPHA_NONE        = 8'd0;
  localparam int         ALPHA_FALLOFF_PEAK = 160;
  localparam longint     FALLOFF_SCALE      = 6250;

  typedef enum logic [2:0] {
    REGION_NONE,
    REGION_MAIN_CORE,
    REGION_MAIN_FALLOFF,
    REGION_SECOND_CORE,
    REGION_SECOND_RING
  } region_t;

  typedef enum logic [2:0] {
    CFG_MAIN_CX,
    CFG_MAIN_CY,
    CFG_MAIN_R,
    CFG_SEC_CX,
    CFG_SEC_CY,
    CFG_SEC_R,
    CFG_HL_COLOR
  } cfg_index_t;

  typedef struct packed {
    logic [9:0]  main_cx;
    logic [9:0]  main_cy;
    logic [7:0]  main_r;
    logic [9:0]  sec_cx;
    logic [9:0]  sec_cy;
    logic [15:0] main_rsq;
    logic [15:0] main_csq;
    logic [15:0] sec_rsq;
    logic [15:0] sec_csq;
  } cfg_t;

  typedef struct packed {
    logic [15:0] base;
    logic [7:0]  alpha;
    region_t     region;
  } queue_entry_t;

  typedef logic [7:0] alpha_lut_t [256];

  // alpha(f) = largest a in 0..160 with a^5 <= 6250*(256-f)^3
  function automatic alpha_lut_t build_alpha_lut();
    alpha_lut_t lut;
    longint unsigned rem;
    longint unsigned lim;
    longint unsigned p;
    int best;
    for (int f = 0; f < 256; f++) begin
      rem  = longint'(256 - f);
      lim  = rem * rem * rem * FALLOFF_SCALE;
      best = 0;
      for (int a = 0; a <= ALPHA_FALLOFF_PEAK; a++) begin
        p = longint'(a);
        p = p * p * p * p * p;
        if (p <= lim) best = a;
      end
      lut[f] = 8'(best);
    end
    return lut;
  endfunction

  localparam alpha_lut_t ALPHA_LUT = build_alpha_lut();

endpackage

/* rtl/rhc_front.sv */
// rhc_front: accepts pixel beats, measures distances to both highlight
// centers, runs the root and divide pipeline and classifies each pixel.
// Depends on rhc_pkg.
module rhc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  rhc_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            pixel_x,
  input  logic [7:0]            pixel_y,
  input  logic [15:0]           bg_color,
  output logic                  push,
  output rhc_pkg::queue_entry_t push_data,
  input  logic                  full
);

  typedef struct packed {
    logic [15:0] base;
    logic        in1;
    logic        core1;
    logic        in2;
    logic        core2;
    logic [15:0] d;
    logic [10:0] srem;
    logic [7:0]  root;
    logic [7:0]  drem;
    logic [7:0]  q;
  } front_item_t;

  function automatic front_item_t sqrt_step(front_item_t it, logic [2:0] step);
    front_item_t o;
    logic [3:0]  pos;
    logic [10:0] rem_sh;
    logic [10:0] trial;
    o      = it;
    pos    = {~step, 1'b0};
    rem_sh = {it.srem[8:0], it.d[pos +: 2]};
    trial  = {1'b0, it.root, 2'b01};
    if (rem_sh >= trial) begin
      o.srem = rem_sh - trial;
      o.root = {it.root[6:0], 1'b1};
    end else begin
      o.srem = rem_sh;
      o.root = {it.root[6:0], 1'b0};
    end
    o.drem = o.root;
    o.q    = '0;
    return o;
  endfunction

  function automatic front_item_t div_step(front_item_t it, logic [7:0] r);
    front_item_t o;
    logic [8:0]  sh;
    logic [8:0]  diff;
    o    = it;
    sh   = {it.drem, 1'b0};
    diff = sh - {1'b0, r};
    if (sh >= {1'b0, r}) begin
      o.drem = diff[7:0];
      o.q    = {it.q[6:0], 1'b1};
    end else begin
      o.drem = sh[7:0];
      o.q    = {it.q[6:0], 1'b0};
    end
    return o;
  endfunction

  logic               en;
  logic               a_valid;
  logic               b_valid;
  logic [15:0]        a_base;
  logic [15:0]        b_base;
  logic signed [10:0] a_dx1, a_dy1, a_dx2, a_dy2;
  logic [19:0]        b_sq1x, b_sq1y, b_sq2x, b_sq2y;
  logic signed [21:0] p1x, p1y, p2x, p2y;
  logic [20:0]        d1, d2;
  front_item_t        head;
  front_item_t        pipe [rhc_pkg::PIPE_STAGES+1];
  logic [rhc_pkg::PIPE_STAGES:0] pipe_valid;
  front_item_t        last;
  logic [7:0]         alpha_f;

  assign en       = !(pipe_valid[rhc_pkg::PIPE_STAGES] && full);
  assign in_ready = en && !rst;
  assign push     = pipe_valid[rhc_pkg::PIPE_STAGES] && !full;
  assign last     = pipe[rhc_pkg::PIPE_STAGES];

  always_comb begin
    p1x = a_dx1 * a_dx1;
    p1y = a_dy1 * a_dy1;
    p2x = a_dx2 * a_dx2;
    p2y = a_dy2 * a_dy2;
    d1  = {1'b0, b_sq1x} + {1'b0, b_sq1y};
    d2  = {1'b0, b_sq2x} + {1'b0, b_sq2y};
    head       = '0;
    head.base  = b_base;
    head.in1   = d1 < {5'd0, cfg.main_rsq};
    head.core1 = d1 < {5'd0, cfg.main_csq};
    head.in2   = d2 < {5'd0, cfg.sec_rsq};
    head.core2 = d2 < {5'd0, cfg.sec_csq};
    head.d     = d1[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      pipe_valid <= '0;
    end else if (en) begin
      a_valid    <= in_valid;
      b_valid    <= a_valid;
      pipe_valid <= {pipe_valid[rhc_pkg::PIPE_STAGES-1:0], b_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_base <= bg_color;
      a_dx1  <= $signed({3'b000, pixel_x}) - $signed({cfg.main_cx[9], cfg.main_cx});
      a_dy1  <= $signed({3'b000, pixel_y}) - $signed({cfg.main_cy[9], cfg.main_cy});
      a_dx2  <= $signed({3'b000, pixel_x}) - $signed({cfg.sec_cx[9], cfg.sec_cx});
      a_dy2  <= $signed({3'b000, pixel_y}) - $signed({cfg.sec_cy[9], cfg.sec_cy});
      b_base <= a_base;
      b_sq1x <= p1x[19:0];
      b_sq1y <= p1y[19:0];
      b_sq2x <= p2x[19:0];
      b_sq2y <= p2y[19:0];
      pipe[0] <= head;
      for (int k = 0; k < rhc_pkg::PIPE_STAGES; k++) begin
        if (k < rhc_pkg::ROOT_W) begin
          pipe[k+1] <= sqrt_step(pipe[k], 3'(k));
        end else begin
          pipe[k+1] <= div_step(pipe[k], cfg.main_r);
        end
      end
    end
  end

  always_comb begin
    alpha_f        = rhc_pkg::ALPHA_LUT[last.q];
    push_data.base = last.base;
    if (last.in1 && last.core1) begin
      push_data.alpha  = rhc_pkg::ALPHA_MAIN_CORE;
      push_data.region = rhc_pkg::REGION_MAIN_CORE;
    end else if (last.in1 && (alpha_f > rhc_pkg::ALPHA_MIN_APPLY)) begin
      push_data.alpha  = alpha_f;
      push_data.region = rhc_pkg::REGION_MAIN_FALLOFF;
    end else if (last.in2 && last.core2) begin
      push_data.alpha  = rhc_pkg::ALPHA_SECOND_CORE;
      push_data.region = rhc_pkg::REGION_SECOND_CORE;
    end else if (last.in2) begin
      push_data.alpha  = rhc_pkg::ALPHA_SECOND_RING;
      push_data.region = rhc_pkg::REGION_SECOND_RING;
    end else begin
      push_data.alpha  = rhc_pkg::ALPHA_NONE;
      push_data.region = rhc_pkg::REGION_NONE;
    end
  end

endmodule

/* rtl/rhc_queue.sv */
// rhc_queue: short FIFO of classified pixels between front and back.
// Depends on rhc_pkg.
module rhc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rhc_pkg::queue_entry_t push_data,
  output logic                  full,
  input  logic                  pop,
  output rhc_pkg::queue_entry_t pop_data,
  output logic                  empty
);

  localparam int PTR_W = rhc_pkg::QUEUE_PTR_W;
  localparam int CNT_W = rhc_pkg::QUEUE_CNT_W;

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    return (p == PTR_W'(rhc_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  rhc_pkg::queue_entry_t mem [rhc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;

  assign full     = count == CNT_W'(rhc_pkg::QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= next_ptr(wr_ptr);
      if (pop) rd_ptr <= next_ptr(rd_ptr);
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_fill: assert property (@(posedge clk) disable iff (rst) (push && !pop) |=> !empty)
    else $error("queue empty after push");

endmodule

/* rtl/rhc_back.sv */
// rhc_back: blends each queued pixel with the highlight color and holds the
// result beat until taken. Depends on rhc_pkg.
module rhc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  rhc_pkg::queue_entry_t entry,
  input  logic                  empty,
  output logic                  pop,
  input  logic [15:0]           overlay,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_color,
  output rhc_pkg::region_t      region
);

  // floor(x/255), exact for x < 16320
  function automatic logic [5:0] div255(logic [13:0] x);
    logic [15:0] t;
    t = {2'b00, x} + {10'd0, x[13:8]} + 16'd1;
    return t[13:8];
  endfunction

  logic             en;
  logic [15:0]      b_sw;
  logic [15:0]      o_sw;
  logic [7:0]       inv;
  logic             s1_valid;
  logic [12:0]      s1_r;
  logic [13:0]      s1_g;
  logic [12:0]      s1_b;
  rhc_pkg::region_t s1_region;
  logic [5:0]       q_r;
  logic [5:0]       q_g;
  logic [5:0]       q_b;
  logic [15:0]      packed_rgb;

  assign en   = !out_valid || out_ready;
  assign pop  = en && !empty;
  assign b_sw = {entry.base[7:0], entry.base[15:8]};
  assign o_sw = {overlay[7:0], overlay[15:8]};
  assign inv  = 8'd255 - entry.alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= !empty;
      out_valid <= s1_valid;
    end
  end

  always_comb begin
    q_r        = div255({1'b0, s1_r});
    q_g        = div255(s1_g);
    q_b        = div255({1'b0, s1_b});
    packed_rgb = {q_r[4:0], q_g, q_b[4:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r      <= 13'(b_sw[15:11] * inv) + 13'(o_sw[15:11] * entry.alpha);
      s1_g      <= 14'(b_sw[10:5] * inv) + 14'(o_sw[10:5] * entry.alpha);
      s1_b      <= 13'(b_sw[4:0] * inv) + 13'(o_sw[4:0] * entry.alpha);
      s1_region <= entry.region;
      out_color <= {packed_rgb[7:0], packed_rgb[15:8]};
      region    <= s1_region;
    end
  end

endmodule

/* rtl/radial_highlight_compositor.sv */
// radial_highlight_compositor: top level with the register file and the
// front, queue and back parts. Depends on rhc_pkg, rhc_front, rhc_queue, rhc_back.
// Throughput: one beat per clock unless m_axis_tready holds the output back;
// the 8-step root and 8-step divide are fully pipelined.
// A 4-entry queue lets front and back stall independently.
// Reset (rst, synchronous): empties the pipeline and queue, loads register defaults.
module radial_highlight_compositor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // pixel_x[7:0], pixel_y[15:8], bg_color[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_color[15:0]
  output logic [2:0]  m_axis_tuser,  // region[2:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [9:0]  main_cx, main_cy, sec_cx, sec_cy;
  logic [7:0]  main_r, sec_r;
  logic [15:0] hl_color;
  logic [15:0] third_prod;
  logic [6:0]  main_core_r, sec_core_r;
  logic [15:0] main_rsq, main_csq, sec_rsq, sec_csq;

  rhc_pkg::cfg_t         cfg;
  rhc_pkg::queue_entry_t push_data, pop_data;
  logic                  push, pop, full, empty;
  rhc_pkg::region_t      region;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_cx  <= 10'd120;
      main_cy  <= 10'd120;
      main_r   <= 8'd3;
      sec_cx   <= 10'd120;
      sec_cy   <= 10'd120;
      sec_r    <= 8'd2;
      hl_color <= 16'hFFFF;
    end else if (cfg_we) begin
      case (rhc_pkg::cfg_index_t'(cfg_index))
        rhc_pkg::CFG_MAIN_CX:  main_cx  <= cfg_data[9:0];
        rhc_pkg::CFG_MAIN_CY:  main_cy  <= cfg_data[9:0];
        rhc_pkg::CFG_MAIN_R:   main_r   <= cfg_data[7:0];
        rhc_pkg::CFG_SEC_CX:   sec_cx   <= cfg_data[9:0];
        rhc_pkg::CFG_SEC_CY:   sec_cy   <= cfg_data[9:0];
        rhc_pkg::CFG_SEC_R:    sec_r    <= cfg_data[7:0];
        rhc_pkg::CFG_HL_COLOR: hl_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // r/3 as (r*171)>>9, exact for 8-bit r
  assign third_prod = 16'(main_r) * 16'd171;

  always_ff @(posedge clk) begin
    main_core_r <= (third_prod[15:9] == 7'd0) ? 7'd1 : third_prod[15:9];
    sec_core_r  <= (sec_r[7:1] == 7'd0) ? 7'd1 : sec_r[7:1];
    main_rsq    <= 16'(main_r) * 16'(main_r);
    sec_rsq     <= 16'(sec_r) * 16'(sec_r);
    main_csq    <= 16'(main_core_r) * 16'(main_core_r);
    sec_csq     <= 16'(sec_core_r) * 16'(sec_core_r);
  end

  always_comb begin
    cfg.main_cx  = main_cx;
    cfg.main_cy  = main_cy;
    cfg.main_r   = main_r;
    cfg.sec_cx   = sec_cx;
    cfg.sec_cy   = sec_cy;
    cfg.main_rsq = main_rsq;
    cfg.main_csq = main_csq;
    cfg.sec_rsq  = sec_rsq;
    cfg.sec_csq  = sec_csq;
  end

  rhc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .pixel_x    (s_axis_tdata[7:0]),
    .pixel_y    (s_axis_tdata[15:8]),
    .bg_color   (s_axis_tdata[31:16]),
    .push       (push),
    .push_data  (push_data),
    .full       (full)
  );

  rhc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  rhc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .entry     (pop_data),
    .empty     (empty),
    .pop       (pop),
    .overlay   (hl_color),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_color (m_axis_tdata),
    .region    (region)
  );

  assign m_axis_tuser = region;

endmodule
